>>> rtl/core/mstkp_pkg.sv
package mstkp_pkg;

  // Default sizes of the slot table.
  localparam int SLOT_COUNT_DEF  = 64;
  localparam int COUNT_WIDTH_DEF = 10;

  // A tick delivers at most this many events; later events are dropped.
  localparam int MAX_RESULTS = 64;

  // Galois LFSR, taps 32, 22, 2 and 1.
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  // Remainder bits resolved per clock by the interval divider.
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES         = 32 / DIV_BITS_PER_CYCLE;

  // Item modes.
  localparam logic [1:0] MODE_PRESS   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_INDEX_W     = 2;
  localparam logic [1:0]  REG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0]  REG_MAX_INTERVAL = 2'd1;
  localparam logic [1:0]  REG_PULSE_UP     = 2'd2;
  localparam logic [1:0]  REG_RANDOM_SEED  = 2'd3;

  // Register values after reset.
  localparam logic [9:0]  MIN_INTERVAL_RST = 10'd20;
  localparam logic [9:0]  MAX_INTERVAL_RST = 10'd26;
  localparam logic [9:0]  PULSE_UP_RST     = 10'd3;
  localparam logic [31:0] RANDOM_SEED_RST  = 32'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  position;
    logic [31:0] keycode;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  slot_position;
    logic [31:0] key_code;
    logic        key_down;
    logic        bad_position;
    logic        last_of_run;
  } out_item_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] w);
    logic [31:0] v;
    v = {1'b0, w[31:1]};
    if (w[0]) begin
      v = v ^ LFSR_MASK;
    end
    return v;
  endfunction

endpackage

>>> rtl/core/multi_slot_turbo_key_pulser.sv
// A press runs read, evaluate, the interval divider (only if the range holds more than one
// value), finish and flush; a release runs read, evaluate and flush. A tick evaluates every
// slot in turn, with a divider pass for each slot that draws; output stalls hold the flow.
// One item is in flight at once.
// Reset (rst_n low, synchronous) clears all control state and the per-slot valid bits at
// once; there is no clearing pass, so an item can be taken in the cycle after reset.
module multi_slot_turbo_key_pulser #(
  parameter int SLOT_COUNT  = mstkp_pkg::SLOT_COUNT_DEF,
  parameter int COUNT_WIDTH = mstkp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mstkp_pkg::in_item_t                 in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mstkp_pkg::out_item_t                out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mstkp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                         cfg_data
);
  import mstkp_pkg::*;

  localparam int AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNTW = $clog2(MAX_RESULTS + 1);
  localparam int DCW  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam logic [AW-1:0]   LAST_SLOT = AW'(SLOT_COUNT - 1);
  localparam logic [16:0]     CNT_MAX   = 17'((1 << COUNT_WIDTH) - 1);
  localparam logic [CNTW-1:0] RES_LIMIT = CNTW'(MAX_RESULTS);

  // One memory word holds everything the block knows about a slot.
  typedef struct packed {
    logic [31:0]            keycode;
    logic                   active;
    logic                   down;
    logic                   phase_up;
    logic [COUNT_WIDTH-1:0] countdown;
  } slot_t;

  // The sequencer walks each item through read, evaluate, an optional interval draw, a finish
  // that sets the key down, and a flush that hands the held event over as the last one of the run.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_DIV   = 6'b000100,
    S_FIN   = 6'b001000,
    S_FLUSH = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  // Slot memory: one write and one registered read per cycle.
  slot_t                   slot_mem [SLOT_COUNT];
  slot_t                   rd_data_r;
  logic                    rd_valid_r;
  logic [SLOT_COUNT-1:0]   valid_r;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  slot_t                   wr_data;

  state_t                  state_r, state_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic [31:0]             code_r, code_nxt;
  logic [AW-1:0]           scan_r, scan_nxt;
  logic [CNTW-1:0]         count_r, count_nxt;
  slot_t                   cur_r, cur_nxt;
  logic [31:0]             div_q_r, div_q_nxt;
  logic [9:0]              div_rem_r, div_rem_nxt;
  logic [DCW-1:0]          div_cnt_r, div_cnt_nxt;
  logic [31:0]             lfsr_r, lfsr_nxt;
  logic [9:0]              min_r, min_nxt;
  logic [9:0]              max_r, max_nxt;
  logic [9:0]              pulse_r, pulse_nxt;
  logic                    pend_v_r, pend_v_nxt;
  out_item_t               pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  slot_t                   slot_eff;
  logic                    out_free;
  logic                    can_emit;
  logic                    emit_req;
  out_item_t               emit_item;
  logic                    slot_done;
  logic                    start_draw;
  logic                    pos_bad;
  logic [10:0]             div_d;
  logic [9:0]              div_rem_step;
  logic [31:0]             div_q_step;
  logic [10:0]             interval;
  logic [10:0]             down_time;
  logic [COUNT_WIDTH-1:0]  down_cnt;
  logic [COUNT_WIDTH-1:0]  pulse_cnt;
  logic [31:0]             lfsr_adv;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The output register frees up when it is empty or its transfer completes this cycle.
  // A new event may be produced when nothing is held, or the held one can move out.
  assign out_free = !out_valid_r || out_ready;
  assign can_emit = !pend_v_r || out_free;
  assign pos_bad  = ({1'b0, in_item.position} >= 9'(SLOT_COUNT));
  assign lfsr_adv = lfsr_step(lfsr_r);

  // Slots never written read back in their reset state.
  always_comb begin
    slot_eff = rd_data_r;
    if (!rd_valid_r) begin
      slot_eff.active    = 1'b0;
      slot_eff.down      = 1'b0;
      slot_eff.phase_up  = 1'b0;
      slot_eff.countdown = '0;
    end
  end

  // Restoring remainder, several bits per cycle. The divisor is the size of the
  // interval range and only matters when max is above min.
  assign div_d = {1'b0, max_r} - {1'b0, min_r} + 11'd1;

  always_comb begin
    logic [10:0] t;
    logic [9:0]  r;
    logic [31:0] q;
    r = div_rem_r;
    q = div_q_r;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      t = {r, q[31]};
      q = {q[30:0], 1'b0};
      if (t >= div_d) begin
        t = t - div_d;
      end
      r = t[9:0];
    end
    div_rem_step = r;
    div_q_step   = q;
  end

  // Down time of the new cycle: the drawn interval less the released gap, at least one,
  // saturated to the countdown range.
  assign interval  = {1'b0, min_r} + {1'b0, div_rem_r};
  assign down_time = (interval > {1'b0, pulse_r}) ? (interval - {1'b0, pulse_r}) : 11'd1;
  assign down_cnt  = ({6'b0, down_time} > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                                   : COUNT_WIDTH'({6'b0, down_time});
  assign pulse_cnt = ({7'b0, pulse_r} > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                                 : COUNT_WIDTH'({7'b0, pulse_r});

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    code_nxt      = code_r;
    scan_nxt      = scan_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    lfsr_nxt      = lfsr_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    pulse_nxt     = pulse_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    rd_en         = 1'b0;
    rd_addr       = scan_r;
    wr_en         = 1'b0;
    wr_data       = cur_r;
    emit_req      = 1'b0;
    emit_item     = '0;
    slot_done     = 1'b0;
    start_draw    = 1'b0;

    emit_item.slot_position = 8'(scan_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_item.mode;
          code_nxt  = in_item.keycode;
          count_nxt = '0;
          case (in_item.mode)
            MODE_PRESS, MODE_RELEASE: begin
              if (pos_bad) begin
                // Nothing is held here, so the error event goes straight to the holding stage.
                pend_v_nxt             = 1'b1;
                pend_nxt               = '0;
                pend_nxt.slot_position = in_item.position;
                pend_nxt.bad_position  = 1'b1;
                count_nxt              = CNTW'(1);
                state_nxt              = S_FLUSH;
              end else begin
                scan_nxt  = in_item.position[AW-1:0];
                rd_en     = 1'b1;
                rd_addr   = in_item.position[AW-1:0];
                state_nxt = S_EVAL;
              end
            end
            MODE_TICK: begin
              scan_nxt  = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_EVAL;
            end
            default: begin
              state_nxt = S_FLUSH;
            end
          endcase
        end
      end

      S_EVAL: begin
        emit_item.key_code = slot_eff.keycode;
        emit_item.key_down = 1'b0;
        case (mode_r)
          MODE_PRESS: begin
            // A key that is still down is released before the new press.
            if (!slot_eff.down || can_emit) begin
              emit_req          = slot_eff.down;
              cur_nxt.keycode   = code_r;
              cur_nxt.active    = 1'b1;
              cur_nxt.down      = 1'b0;
              cur_nxt.phase_up  = 1'b0;
              cur_nxt.countdown = slot_eff.countdown;
              start_draw        = 1'b1;
            end
          end
          MODE_RELEASE: begin
            if (!slot_eff.down || can_emit) begin
              emit_req          = slot_eff.down;
              wr_en             = 1'b1;
              wr_data.keycode   = slot_eff.keycode;
              wr_data.active    = 1'b0;
              wr_data.down      = 1'b0;
              wr_data.phase_up  = 1'b0;
              wr_data.countdown = '0;
              slot_done         = 1'b1;
            end
          end
          default: begin
            if (!slot_eff.active) begin
              slot_done = 1'b1;
            end else if (slot_eff.countdown > COUNT_WIDTH'(1)) begin
              wr_en             = 1'b1;
              wr_data           = slot_eff;
              wr_data.countdown = slot_eff.countdown - COUNT_WIDTH'(1);
              slot_done         = 1'b1;
            end else if (!slot_eff.phase_up) begin
              // End of the down phase: release and start the gap.
              if (!slot_eff.down || can_emit) begin
                emit_req          = slot_eff.down;
                wr_en             = 1'b1;
                wr_data           = slot_eff;
                wr_data.down      = 1'b0;
                wr_data.phase_up  = 1'b1;
                wr_data.countdown = pulse_cnt;
                slot_done         = 1'b1;
              end
            end else begin
              cur_nxt    = slot_eff;
              start_draw = 1'b1;
            end
          end
        endcase
      end

      S_DIV: begin
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r + DCW'(1);
        if (div_cnt_r == DCW'(DIV_CYCLES - 1)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        emit_item.key_code = cur_r.keycode;
        emit_item.key_down = 1'b1;
        if (cur_r.down || can_emit) begin
          emit_req          = !cur_r.down;
          wr_en             = 1'b1;
          wr_data           = cur_r;
          wr_data.active    = 1'b1;
          wr_data.down      = 1'b1;
          wr_data.phase_up  = 1'b0;
          wr_data.countdown = down_cnt;
          slot_done         = 1'b1;
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt             = pend_r;
          out_item_nxt.last_of_run = 1'b1;
          pend_v_nxt               = 1'b0;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new event pushes the held one out; past the limit events are dropped.
    if (emit_req && (count_r < RES_LIMIT)) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = pend_r;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_item;
      count_nxt  = count_r + CNTW'(1);
    end

    // Interval draw: the LFSR steps only when the range holds more than one value.
    if (start_draw) begin
      div_rem_nxt = '0;
      div_cnt_nxt = '0;
      if (max_r > min_r) begin
        lfsr_nxt  = lfsr_adv;
        div_q_nxt = lfsr_adv;
        state_nxt = S_DIV;
      end else begin
        state_nxt = S_FIN;
      end
    end

    // Press and release touch one slot; a tick moves on until the last slot.
    if (slot_done) begin
      if ((mode_r != MODE_TICK) || (scan_r == LAST_SLOT)) begin
        state_nxt = S_FLUSH;
      end else begin
        scan_nxt  = scan_r + AW'(1);
        rd_en     = 1'b1;
        rd_addr   = scan_r + AW'(1);
        state_nxt = S_EVAL;
      end
    end

    // Configuration writes are for the user to make only while the block is idle; the block does not enforce it.
    if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_INTERVAL: min_nxt   = cfg_data[9:0];
        REG_MAX_INTERVAL: max_nxt   = cfg_data[9:0];
        REG_PULSE_UP:     pulse_nxt = cfg_data[9:0];
        REG_RANDOM_SEED:  lfsr_nxt  = (cfg_data != 32'd0) ? cfg_data : 32'd1;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lfsr_r      <= RANDOM_SEED_RST;
      min_r       <= MIN_INTERVAL_RST;
      max_r       <= MAX_INTERVAL_RST;
      pulse_r     <= PULSE_UP_RST;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lfsr_r      <= lfsr_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      pulse_r     <= pulse_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[scan_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    code_r     <= code_nxt;
    scan_r     <= scan_nxt;
    cur_r      <= cur_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[scan_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= slot_mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RES_LIMIT)
    else $error("event count passed the per-item limit");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en && (rd_addr == scan_r)))
    else $error("slot read and written in the same cycle");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held event left over when taking a new item");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && (max_r > min_r)) |-> ({1'b0, div_rem_r} < div_d))
    else $error("interval remainder out of range");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FLUSH) && pend_v_r && out_free) |=>
      (out_valid_r && out_item_r.last_of_run))
    else $error("final event not marked as last of run");
`endif

endmodule
